FILE: rtl/tser_pkg.sv
// ----------------------------------------------------------------------------
// tser_pkg: shared types and constants of the time-scale envelope ramp
// Payload structs, command and phase codes, register indexes, controller
// states and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tser_pkg;

  // Q2.14 unity and rounding half
  localparam logic [15:0] ONE_Q14  = 16'd16384;
  localparam logic [15:0] HALF_Q14 = 16'd8192;
  localparam int unsigned FRAC_W   = 14;

  // Elapsed time saturates at the top of its 25-bit range
  localparam int unsigned ELAPSED_W = 25;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Register widths and reset values
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned CFG_W  = 24;
  localparam logic [15:0]      SLOW_SCALE_RST = 16'd8192;
  localparam logic [DUR_W-1:0] ENTER_TIME_RST = 24'd250000;
  localparam logic [DUR_W-1:0] HOLD_TIME_RST  = 24'd1000000;
  localparam logic [DUR_W-1:0] EXIT_TIME_RST  = 24'd250000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SLOW_SCALE = 2'd0,
    CFG_ENTER_TIME = 2'd1,
    CFG_HOLD_TIME  = 2'd2,
    CFG_EXIT_TIME  = 2'd3
  } cfg_idx_e;

  // Input commands
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_TRIGGER    = 2'd1,
    CMD_BEGIN_EXIT = 2'd2,
    CMD_FORCE_END  = 2'd3
  } cmd_e;

  // Envelope phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ENTER = 2'd1,
    PH_HOLD  = 2'd2,
    PH_EXIT  = 2'd3
  } phase_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_MUL,
    ST_BLEND,
    ST_UPD,
    ST_EMIT
  } state_e;

  // Payloads
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] time_scale;
    logic [1:0]  phase;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mul;
    logic blend;
    logic commit;
    logic emit;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic ramp;
    logic frac_full;
    logic div_last;
  } stat_t;

endpackage

FILE: rtl/tser_dp.sv
// ----------------------------------------------------------------------------
// tser_dp: envelope datapath
// Configuration registers, envelope state, restoring divider for the ramp
// fraction, blend multiplier and the result payload register.
// ----------------------------------------------------------------------------
module tser_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  tser_pkg::in_item_t in_data,
  input  tser_pkg::ctl_t     ctl,
  output tser_pkg::stat_t    stat,
  output tser_pkg::out_item_t out_data
);

  localparam int unsigned EW = tser_pkg::ELAPSED_W;
  localparam int unsigned DW = tser_pkg::DUR_W;
  localparam int unsigned FW = tser_pkg::FRAC_W;

  // Configuration
  logic [15:0]   slow_scale_r;
  logic [DW-1:0] enter_time_r;
  logic [DW-1:0] hold_time_r;
  logic [DW-1:0] exit_time_r;

  // Envelope state
  tser_pkg::phase_e phase_r, phase_nxt;
  logic [EW-1:0]    elapsed_r, elapsed_nxt;
  logic [15:0]      scale_r, scale_nxt;

  // Item and arithmetic
  tser_pkg::in_item_t   item_r;
  logic [DW-1:0]        rem_r;
  logic [FW:0]          frac_r;
  logic [3:0]           cnt_r;
  logic signed [32:0]   prod_r;
  logic [15:0]          blend_r;
  tser_pkg::out_item_t  out_r;

  logic [DW-1:0]      dur;
  logic [15:0]        ramp_a;
  logic [15:0]        ramp_b;
  logic [DW:0]        rem_sh;
  logic               q_bit;
  logic signed [16:0] diff;
  logic signed [32:0] acc;
  logic [EW:0]        sum;
  logic [EW-1:0]      acc_time;
  logic               reached;
  tser_pkg::cmd_e     cmd;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_scale_r <= tser_pkg::SLOW_SCALE_RST;
      enter_time_r <= tser_pkg::ENTER_TIME_RST;
      hold_time_r  <= tser_pkg::HOLD_TIME_RST;
      exit_time_r  <= tser_pkg::EXIT_TIME_RST;
    end else if (cfg_wr_en) begin
      case (tser_pkg::cfg_idx_e'(cfg_index))
        tser_pkg::CFG_SLOW_SCALE: slow_scale_r <= cfg_data[15:0];
        tser_pkg::CFG_ENTER_TIME: enter_time_r <= cfg_data;
        tser_pkg::CFG_HOLD_TIME:  hold_time_r  <= cfg_data;
        tser_pkg::CFG_EXIT_TIME:  exit_time_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select phase duration and ramp end points
  always_comb begin
    case (phase_r)
      tser_pkg::PH_ENTER: begin
        dur    = enter_time_r;
        ramp_a = tser_pkg::ONE_Q14;
        ramp_b = slow_scale_r;
      end
      tser_pkg::PH_HOLD: begin
        dur    = hold_time_r;
        ramp_a = slow_scale_r;
        ramp_b = slow_scale_r;
      end
      tser_pkg::PH_EXIT: begin
        dur    = exit_time_r;
        ramp_a = slow_scale_r;
        ramp_b = tser_pkg::ONE_Q14;
      end
      default: begin
        dur    = hold_time_r;
        ramp_a = tser_pkg::ONE_Q14;
        ramp_b = tser_pkg::ONE_Q14;
      end
    endcase
  end

  assign cmd = tser_pkg::cmd_e'(item_r.command);

  // Status back to the controller
  assign stat.ramp      = (cmd == tser_pkg::CMD_TICK) &&
                          ((phase_r == tser_pkg::PH_ENTER) || (phase_r == tser_pkg::PH_EXIT));
  assign stat.frac_full = (elapsed_r >= {1'b0, dur});
  assign stat.div_last  = (cnt_r == 4'(FW - 1));

  // One restoring step: fraction bits below unity
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, dur});

  // Capture item, run divider, multiply and round, and register the result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.div_init) begin
      rem_r  <= elapsed_r[DW-1:0];
      frac_r <= stat.frac_full ? (FW+1)'(tser_pkg::ONE_Q14) : '0;
      cnt_r  <= '0;
    end else if (ctl.div_step) begin
      rem_r  <= q_bit ? DW'(rem_sh - {1'b0, dur}) : rem_sh[DW-1:0];
      frac_r <= {frac_r[FW-1:0], q_bit};
      cnt_r  <= cnt_r + 4'd1;
    end
    if (ctl.mul) begin
      prod_r <= diff * $signed({1'b0, frac_r});
    end
    if (ctl.blend) begin
      blend_r <= acc[29:14];
    end
    if (ctl.emit) begin
      out_r.time_scale <= scale_r;
      out_r.phase      <= phase_r;
    end
  end

  assign diff = $signed({1'b0, ramp_b}) - $signed({1'b0, ramp_a});
  assign acc  = $signed({3'b000, ramp_a, 14'b0}) + prod_r +
                $signed({17'b0, tser_pkg::HALF_Q14});

  // Accumulate elapsed time with saturation
  assign sum      = {1'b0, elapsed_r} + {(EW+1-16)'(0), item_r.delta_time};
  assign acc_time = sum[EW] ? tser_pkg::ELAPSED_MAX : sum[EW-1:0];
  assign reached  = (acc_time >= {1'b0, dur});

  // Envelope state update
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    scale_nxt   = scale_r;
    case (cmd)
      tser_pkg::CMD_TRIGGER: begin
        elapsed_nxt = '0;
        phase_nxt   = tser_pkg::PH_ENTER;
      end
      tser_pkg::CMD_BEGIN_EXIT: begin
        phase_nxt = tser_pkg::PH_EXIT;
      end
      tser_pkg::CMD_FORCE_END: begin
        scale_nxt = tser_pkg::ONE_Q14;
        phase_nxt = tser_pkg::PH_IDLE;
      end
      default: begin
        case (phase_r)
          tser_pkg::PH_ENTER: begin
            if (reached) begin
              scale_nxt   = slow_scale_r;
              elapsed_nxt = '0;
              phase_nxt   = tser_pkg::PH_HOLD;
            end else begin
              scale_nxt   = blend_r;
              elapsed_nxt = acc_time;
            end
          end
          tser_pkg::PH_HOLD: begin
            scale_nxt = slow_scale_r;
            if (reached) begin
              elapsed_nxt = '0;
              phase_nxt   = tser_pkg::PH_EXIT;
            end else begin
              elapsed_nxt = acc_time;
            end
          end
          tser_pkg::PH_EXIT: begin
            elapsed_nxt = acc_time;
            if (reached) begin
              scale_nxt = tser_pkg::ONE_Q14;
              phase_nxt = tser_pkg::PH_IDLE;
            end else begin
              scale_nxt = blend_r;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // Hold envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tser_pkg::PH_IDLE;
      elapsed_r <= '0;
      scale_r   <= tser_pkg::ONE_Q14;
    end else if (ctl.commit) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      scale_r   <= scale_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/tser_ctrl.sv
// ----------------------------------------------------------------------------
// tser_ctrl: envelope controller
// Sequences one item through decode, division and blend for a ramp tick,
// state update and emit, and owns the input stall and the result valid.
// ----------------------------------------------------------------------------
module tser_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  tser_pkg::stat_t stat,
  output tser_pkg::ctl_t  ctl
);

  tser_pkg::state_e state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic             out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tser_pkg::ST_IDLE:   if (in_xfer) state_nxt = tser_pkg::ST_DECODE;
      tser_pkg::ST_DECODE: begin
        if (!stat.ramp) begin
          state_nxt = tser_pkg::ST_UPD;
        end else if (stat.frac_full) begin
          state_nxt = tser_pkg::ST_MUL;
        end else begin
          state_nxt = tser_pkg::ST_DIV;
        end
      end
      tser_pkg::ST_DIV:    if (stat.div_last) state_nxt = tser_pkg::ST_MUL;
      tser_pkg::ST_MUL:    state_nxt = tser_pkg::ST_BLEND;
      tser_pkg::ST_BLEND:  state_nxt = tser_pkg::ST_UPD;
      tser_pkg::ST_UPD:    state_nxt = tser_pkg::ST_EMIT;
      tser_pkg::ST_EMIT:   if (out_free) state_nxt = tser_pkg::ST_IDLE;
      default:             state_nxt = tser_pkg::ST_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      tser_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      tser_pkg::ST_DECODE: ctl.div_init = 1'b1;
      tser_pkg::ST_DIV:    ctl.div_step = 1'b1;
      tser_pkg::ST_MUL:    ctl.mul      = 1'b1;
      tser_pkg::ST_BLEND:  ctl.blend    = 1'b1;
      tser_pkg::ST_UPD:    ctl.commit   = 1'b1;
      tser_pkg::ST_EMIT:   ctl.emit     = out_free;
      default: ;
    endcase
  end

  // Set valid on emit, drop it after the transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tser_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == tser_pkg::ST_DECODE)
    else $error("accepted item did not reach decode");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tser_pkg::ST_DIV) && stat.div_last |=> state_r == tser_pkg::ST_MUL)
    else $error("divider did not hand over to multiply");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r)
    else $error("emitted result not presented");

  a_wait_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tser_pkg::ST_EMIT) && out_valid_r && out_stall |=>
      state_r == tser_pkg::ST_EMIT)
    else $error("result emitted over a stalled one");
`endif

endmodule

FILE: rtl/time_scale_envelope_ramp_top.sv
// ----------------------------------------------------------------------------
// time_scale_envelope_ramp_top: attack/hold/release time-scale envelope
// Linear enter and exit ramps between 1.0 and the slow scale in Q2.14, with
// a hold at the slow scale, driven by tick, trigger, exit and end commands.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | input     | in_valid / in_stall  | in_item_t  (command, delta)
//   out     | output    | out_valid / out_stall| out_item_t (scale, phase)
//   cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// A ramp tick goes from transfer through decode, 14 steps of the restoring
// fraction divider, multiply, round, update and emit; a tick whose position
// is already at unity skips the divider. Other items go through decode,
// update and emit. One item is in flight at a time; input stalls while busy.
// A finished result waits in the output register; the next item completes
// only after it is taken. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module time_scale_envelope_ramp_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  tser_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tser_pkg::out_item_t out_data
);

  tser_pkg::ctl_t  ctl;
  tser_pkg::stat_t stat;

  // Sequence items
  tser_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Compute the envelope
  tser_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

FILE: verif/time_scale_envelope_ramp_top_test.sv
// ----------------------------------------------------------------------------
// time_scale_envelope_ramp_top_test: self-checking bench for the envelope
// Drives tick, trigger, exit and end commands through the valid/stall input
// channel and predicts every result with an in-bench envelope tracker. The
// run starts with directed walks through all phases at reset settings. It
// then runs random envelopes under several register settings, the extremes
// among them, and ends with a long exit creep that saturates elapsed time.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module time_scale_envelope_ramp_top_test;
  import tser_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam logic [DUR_W-1:0] DUR_MAX   = {DUR_W{1'b1}};

  // Envelope tracker: own copy of registers and state, expected results in order
  class envelope_tracker;
    logic [15:0]          slow_scale;
    logic [DUR_W-1:0]     enter_dur;
    logic [DUR_W-1:0]     hold_dur;
    logic [DUR_W-1:0]     exit_dur;
    phase_e               phase;
    logic [ELAPSED_W-1:0] elapsed;
    logic [15:0]          scale;
    out_item_t            expected_scales[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function new();
      slow_scale   = SLOW_SCALE_RST;
      enter_dur    = ENTER_TIME_RST;
      hold_dur     = HOLD_TIME_RST;
      exit_dur     = EXIT_TIME_RST;
      phase        = PH_IDLE;
      elapsed      = '0;
      scale        = ONE_Q14;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_SLOW_SCALE: slow_scale = value[15:0];
        CFG_ENTER_TIME: enter_dur  = value;
        CFG_HOLD_TIME:  hold_dur   = value;
        CFG_EXIT_TIME:  exit_dur   = value;
        default: ;
      endcase
    endfunction

    // Ramp position in Q14, clamped to unity; zero duration counts as done
    function logic [15:0] ramp_pos(logic [ELAPSED_W-1:0] el, logic [DUR_W-1:0] dur);
      logic [63:0] q;
      if (dur == '0)
        return ONE_Q14;
      q = (64'(el) << FRAC_W) / 64'(dur);
      if (q > 64'(ONE_Q14))
        return ONE_Q14;
      return q[15:0];
    endfunction

    // Linear mix from a to b, rounded half up
    function logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] f);
      logic [63:0] acc;
      acc = 64'(a) * (64'(ONE_Q14) - 64'(f)) + 64'(b) * 64'(f) + 64'(HALF_Q14);
      return acc[29:14];
    endfunction

    function void add_elapsed(logic [15:0] delta);
      logic [ELAPSED_W:0] sum;
      sum = {1'b0, elapsed} + (ELAPSED_W+1)'(delta);
      elapsed = (sum > (ELAPSED_W+1)'(ELAPSED_MAX)) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
    endfunction

    // Advance the envelope by one accepted command and queue its result
    function void note_input(in_item_t item);
      out_item_t exp_item;
      case (item.command)
        CMD_TRIGGER: begin
          elapsed = '0;
          phase   = PH_ENTER;
        end
        CMD_BEGIN_EXIT: begin
          phase = PH_EXIT;
        end
        CMD_FORCE_END: begin
          scale = ONE_Q14;
          phase = PH_IDLE;
        end
        default: begin
          case (phase)
            PH_ENTER: begin
              scale = mix(ONE_Q14, slow_scale, ramp_pos(elapsed, enter_dur));
              add_elapsed(item.delta_time);
              if (elapsed >= ELAPSED_W'(enter_dur)) begin
                scale   = slow_scale;
                elapsed = '0;
                phase   = PH_HOLD;
              end
            end
            PH_HOLD: begin
              scale = slow_scale;
              add_elapsed(item.delta_time);
              if (elapsed >= ELAPSED_W'(hold_dur)) begin
                elapsed = '0;
                phase   = PH_EXIT;
              end
            end
            PH_EXIT: begin
              scale = mix(slow_scale, ONE_Q14, ramp_pos(elapsed, exit_dur));
              add_elapsed(item.delta_time);
              if (elapsed >= ELAPSED_W'(exit_dur)) begin
                scale = ONE_Q14;
                phase = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      endcase
      exp_item.time_scale = scale;
      exp_item.phase      = phase;
      expected_scales.push_back(exp_item);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch on %0s at result %0d: got %0d, want %0d",
               what, results_seen, got, want);
      mismatches++;
    endtask

    // Compare one transfer with the oldest expectation
    task check_output(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_scales.size() == 0) begin
        report_mismatch("unexpected result, time_scale", 32'(got.time_scale), 0);
      end else begin
        want = expected_scales.pop_front();
        if (got.time_scale !== want.time_scale)
          report_mismatch("time_scale", 32'(got.time_scale), 32'(want.time_scale));
        if (got.phase !== want.phase)
          report_mismatch("phase", 32'(got.phase), 32'(want.phase));
      end
    endtask

    function int unsigned pending();
      return expected_scales.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  envelope_tracker env_trk;
  bit          idling = 1'b1;
  int unsigned quiet_cycles = 0;

  time_scale_envelope_ramp_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles, then take one transfer
  initial begin
    int unsigned hold_off;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold_off = idling ? $urandom_range(0, 6) : 0;
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      env_trk.check_output(out_data);
      @(negedge clk);
    end
  end

  // Present one command after a random gap and hold it until transfer
  task automatic send_item(cmd_e cmd, logic [15:0] delta);
    in_item_t item;
    int unsigned gap;
    item.command    = cmd;
    item.delta_time = delta;
    gap = idling ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    env_trk.note_input(item);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (env_trk.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register write, then the enable is dropped again
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    env_trk.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic load_settings(logic [15:0] slow, logic [DUR_W-1:0] t_enter,
                               logic [DUR_W-1:0] t_hold, logic [DUR_W-1:0] t_exit);
    drain();
    write_reg(CFG_SLOW_SCALE, CFG_W'(slow));
    write_reg(CFG_ENTER_TIME, t_enter);
    write_reg(CFG_HOLD_TIME, t_hold);
    write_reg(CFG_EXIT_TIME, t_exit);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return DUR_MAX;
    return DUR_W'($urandom_range(1, 300000));
  endfunction

  // Mostly trigger-started envelopes with random ticks, some noise bursts
  task automatic run_envelopes(int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned delta_max;
    sent = 0;
    while (sent < n_items) begin
      idling = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) != 0) begin
        case ($urandom_range(0, 3))
          0:       delta_max = 2047;
          1:       delta_max = 16383;
          default: delta_max = 65535;
        endcase
        send_item(CMD_TRIGGER, 16'($urandom));
        run_len = $urandom_range(4, 48);
        repeat (run_len) begin
          if ($urandom_range(0, 15) == 0)
            send_item(cmd_e'($urandom_range(1, 3)), 16'($urandom));
          else
            send_item(CMD_TICK, 16'($urandom_range(0, delta_max)));
        end
        sent += run_len + 1;
      end else begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_item(cmd_e'($urandom_range(0, 3)), 16'($urandom));
        sent += run_len;
      end
    end
  endtask

  initial begin
    env_trk = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk every phase and command at reset settings
    send_item(CMD_TICK, 16'd0);
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_FORCE_END, 16'hFFFF);
    send_item(CMD_BEGIN_EXIT, 16'd0);
    repeat (4) send_item(CMD_TICK, 16'hFFFF);
    // exit again with elapsed past the duration: position clamps at unity
    send_item(CMD_BEGIN_EXIT, 16'hFFFF);
    send_item(CMD_TICK, 16'd1);
    send_item(CMD_TRIGGER, 16'hFFFF);
    repeat (4) send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'd0);
    send_item(CMD_BEGIN_EXIT, 16'd0);
    send_item(CMD_TICK, 16'd12345);
    send_item(CMD_FORCE_END, 16'hFFFF);
    send_item(CMD_TRIGGER, 16'd0);
    send_item(CMD_TICK, 16'd30000);
    send_item(CMD_TRIGGER, 16'h5555);
    send_item(CMD_TICK, 16'hAAAA);
    send_item(CMD_BEGIN_EXIT, 16'd0);
    send_item(CMD_TICK, 16'hFFFF);

    // Zero durations and the lowest scale, then the largest scale and ramp times
    load_settings(16'd0, '0, '0, '0);
    run_envelopes(60);
    load_settings(16'hFFFF, DUR_MAX, 24'd1, DUR_MAX);
    run_envelopes(60);
    repeat (4) begin
      load_settings(16'($urandom_range(0, 65535)), pick_duration(), pick_duration(),
                    pick_duration());
      run_envelopes(60);
    end

    // Creep elapsed time up through a long exit, re-entering exit whenever a
    // tick has ended it, until elapsed time saturates
    load_settings(16'($urandom_range(0, 65535)), pick_duration(), pick_duration(),
                  DUR_MAX);
    idling = 1'b1;
    repeat (520) begin
      if (env_trk.phase != PH_EXIT)
        send_item(CMD_BEGIN_EXIT, 16'($urandom));
      send_item(CMD_TICK, 16'($urandom_range(65280, 65535)));
    end
    repeat (3) send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_FORCE_END, 16'd0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (env_trk.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
